// ===== rtl/sstls_pkg.sv =====
// Shared types, codes and the character-to-segment table for the display loader.
package sstls_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIG_LEVEL = 2'd1;

  localparam int DIG_OUT_W = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [6:0] PAT_DASH  = 7'h40;
  localparam logic [6:0] PAT_BLANK = 7'h00;

  localparam logic [6:0] DIGIT_PATTERNS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic       known;
    logic       is_dot;
    logic [6:0] pattern;
  } char_dec_t;

  typedef struct packed {
    logic seg_level;
    logic dig_level;
  } cfg_t;

  typedef struct packed {
    logic [6:0]           seg;
    logic                 dot;
    logic [DIG_OUT_W-1:0] digits;
  } pin_t;

  typedef struct packed {
    logic status;
    pin_t pins;
  } result_t;

  function automatic char_dec_t decode_char(input logic [7:0] c);
    char_dec_t d;
    logic [7:0] ofs;
    d = '{known: 1'b0, is_dot: 1'b0, pattern: PAT_BLANK};
    ofs = c - CHAR_ZERO;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.known   = 1'b1;
      d.pattern = DIGIT_PATTERNS[ofs[3:0]];
    end else if (c == CHAR_DASH) begin
      d.known   = 1'b1;
      d.pattern = PAT_DASH;
    end else if (c == CHAR_SPACE) begin
      d.known   = 1'b1;
    end else if (c == CHAR_DOT) begin
      d.is_dot  = 1'b1;
    end
    return d;
  endfunction

endpackage

// ===== rtl/sstls_in_if.sv =====
// Input channel: one text or tick command per beat.
interface sstls_in_if import sstls_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

// ===== rtl/sstls_out_if.sv =====
// Result channel: status and pin levels, one beat per input item.
interface sstls_out_if import sstls_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [6:0]           segment_levels;
  logic                 dot_level;
  logic [DIG_OUT_W-1:0] digit_levels;

  modport source (output valid, output status, output segment_levels,
                  output dot_level, output digit_levels, input ready);
  modport sink   (input valid, input status, input segment_levels,
                  input dot_level, input digit_levels, output ready);
endinterface

// ===== rtl/sstls_cfg_if.sv =====
// Configuration write channel: register index and data per beat.
interface sstls_cfg_if import sstls_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/seven_segment_text_loader_and_scan_top.sv =====
// Multiplexed seven-segment text loader and digit scanner, top level.
// Accepts one item per clock cycle; each item's result beat is registered in
// the output buffer. The text store and scan pin register update in the same
// cycle the item is taken, and a two-entry output buffer lets one more item in
// while a result beat waits, so the input stalls only when two result beats are
// pending. Configuration writes apply to the pins at the next scan tick.
// DIGIT_COUNT sets the number of digits; digit_levels shows the lowest four
// digit enables.
module seven_segment_text_loader_and_scan_top import sstls_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  sstls_in_if.sink    in_bus,
  sstls_out_if.source out_bus,
  sstls_cfg_if.sink   cfg_bus
);

  logic                        in_ready;
  logic                        accept;
  op_t                         op;
  logic                        status;
  logic [DIGIT_COUNT-1:0][6:0] pat;
  logic [DIGIT_COUNT-1:0]      dot;
  pin_t                        pins_nxt;
  cfg_t                        cfg_r;
  result_t                     res, out_res;
  logic                        cfg_wr;

  assign in_bus.ready = in_ready;
  assign accept       = in_bus.valid && in_ready;
  assign op           = op_t'(in_bus.op);

  assign cfg_bus.ready = 1'b1;
  assign cfg_wr        = cfg_bus.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{seg_level: 1'b1, dig_level: 1'b0};
    end else if (cfg_wr) begin
      if (cfg_bus.index == CFG_SEG_LEVEL) cfg_r.seg_level <= cfg_bus.data[0];
      if (cfg_bus.index == CFG_DIG_LEVEL) cfg_r.dig_level <= cfg_bus.data[0];
    end
  end

  sstls_store #(.DIGIT_COUNT(DIGIT_COUNT)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .item_op    (op),
    .item_char  (in_bus.char_code),
    .status     (status),
    .pat_r      (pat),
    .dot_r      (dot)
  );

  sstls_scan #(.DIGIT_COUNT(DIGIT_COUNT)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (accept && (op == OP_TICK)),
    .cfg      (cfg_r),
    .pat      (pat),
    .dot      (dot),
    .pins_nxt (pins_nxt)
  );

  assign res.status = status;
  assign res.pins   = pins_nxt;

  sstls_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (in_ready),
    .pop_valid  (out_bus.valid),
    .pop_ready  (out_bus.ready),
    .pop_data   (out_res)
  );

  assign out_bus.status         = out_res.status;
  assign out_bus.segment_levels = out_res.pins.seg;
  assign out_bus.dot_level      = out_res.pins.dot;
  assign out_bus.digit_levels   = out_res.pins.digits;

endmodule

// ===== rtl/sstls_store.sv =====
// Text loader: pattern and dot store, write position, freeze and justification.
module sstls_store import sstls_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  op_t                          item_op,
  input  logic [7:0]                   item_char,
  output logic                         status,
  output logic [DIGIT_COUNT-1:0][6:0]  pat_r,
  output logic [DIGIT_COUNT-1:0]       dot_r
);

  localparam int WP_W  = $clog2(DIGIT_COUNT + 1);
  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [WP_W-1:0]                wp_r, wp_nxt, wp_dec;
  logic                           frozen_r, frozen_nxt;
  logic [DIGIT_COUNT-1:0][6:0]    pat_nxt;
  logic [DIGIT_COUNT-1:0]         dot_nxt;
  char_dec_t                      dec;
  logic                           open;

  assign dec    = decode_char(item_char);
  assign wp_dec = wp_r - WP_W'(1);
  assign open   = !frozen_r && (wp_r < WP_W'(DIGIT_COUNT));

  always_comb begin
    int src;
    pat_nxt    = pat_r;
    dot_nxt    = dot_r;
    wp_nxt     = wp_r;
    frozen_nxt = frozen_r;
    status     = 1'b0;
    src        = 0;
    if (item_valid) begin
      unique case (item_op)
        OP_START: begin
          pat_nxt    = '0;
          dot_nxt    = '0;
          wp_nxt     = '0;
          frozen_nxt = 1'b0;
        end
        OP_CHAR: begin
          if (open) begin
            if (dec.is_dot) begin
              if (wp_r != '0) dot_nxt[wp_dec[IDX_W-1:0]] = 1'b1;
            end else if (dec.known) begin
              pat_nxt[wp_r[IDX_W-1:0]] = dec.pattern;
              wp_nxt = wp_r + WP_W'(1);
            end else begin
              frozen_nxt = 1'b1;
              status     = 1'b1;
            end
          end
        end
        OP_END: begin
          if (!frozen_r) begin
            frozen_nxt = 1'b1;
            // right-justify a short string, blank the leading positions
            if (wp_r < WP_W'(DIGIT_COUNT)) begin
              for (int i = 0; i < DIGIT_COUNT; i++) begin
                src = i + int'(wp_r) - DIGIT_COUNT;
                if (src >= 0) begin
                  pat_nxt[i] = pat_r[src[IDX_W-1:0]];
                  dot_nxt[i] = dot_r[src[IDX_W-1:0]];
                end else begin
                  pat_nxt[i] = PAT_BLANK;
                  dot_nxt[i] = 1'b0;
                end
              end
            end
          end
        end
        OP_TICK: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= '0;
      dot_r    <= '0;
      wp_r     <= '0;
      frozen_r <= 1'b0;
    end else begin
      pat_r    <= pat_nxt;
      dot_r    <= dot_nxt;
      wp_r     <= wp_nxt;
      frozen_r <= frozen_nxt;
    end
  end

endmodule

// ===== rtl/sstls_scan.sv =====
// Digit scanner: scan position and pin register with polarity applied.
module sstls_scan import sstls_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick,
  input  cfg_t                         cfg,
  input  logic [DIGIT_COUNT-1:0][6:0]  pat,
  input  logic [DIGIT_COUNT-1:0]       dot,
  output pin_t                         pins_nxt
);

  localparam int SP_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [SP_W-1:0]        sp_r, sp_nxt;
  logic [6:0]             seg_r, seg_nxt;
  logic                   dot_r, dot_nxt;
  logic [DIGIT_COUNT-1:0] dig_r, dig_nxt, dig_onehot;

  always_comb begin
    dig_onehot = '0;
    dig_onehot[sp_r] = 1'b1;
    seg_nxt = seg_r;
    dot_nxt = dot_r;
    dig_nxt = dig_r;
    sp_nxt  = sp_r;
    if (tick) begin
      seg_nxt = cfg.seg_level ? pat[sp_r] : ~pat[sp_r];
      dot_nxt = cfg.seg_level ? dot[sp_r] : ~dot[sp_r];
      dig_nxt = cfg.dig_level ? dig_onehot : ~dig_onehot;
      // wrap after the last digit
      sp_nxt  = (sp_r == SP_W'(DIGIT_COUNT - 1)) ? '0 : sp_r + SP_W'(1);
    end
  end

  always_comb begin
    pins_nxt.seg    = seg_nxt;
    pins_nxt.dot    = dot_nxt;
    pins_nxt.digits = '0;
    for (int i = 0; i < DIG_OUT_W; i++) begin
      if (i < DIGIT_COUNT) pins_nxt.digits[i] = dig_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      seg_r <= '0;
      dot_r <= 1'b0;
      dig_r <= '1;
    end else begin
      sp_r  <= sp_nxt;
      seg_r <= seg_nxt;
      dot_r <= dot_nxt;
      dig_r <= dig_nxt;
    end
  end

endmodule

// ===== rtl/sstls_skid.sv =====
// Two-entry result buffer: output register plus skid register.
module sstls_skid import sstls_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    pop;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_r;
  assign pop        = main_valid_r && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        main_r       <= push_data;
      end else begin
        main_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_r       <= push_data;
        main_valid_r <= 1'b1;
      end else begin
        // hold the beat in the skid stage while the output stalls
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule
